/* rtl/bsra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsra_pkg
// Shared types for the safe resource allocator: opcodes, status codes,
// controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package bsra_pkg;

    typedef enum logic [2:0] {
        OP_REQUEST    = 3'd0,
        OP_RELEASE    = 3'd1,
        OP_LOAD_MAX   = 3'd2,
        OP_LOAD_ALLOC = 3'd3,
        OP_LOAD_AVAIL = 3'd4,
        OP_QUERY      = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_CUST    = 3'd1,
        ST_OVER_NEED   = 3'd2,
        ST_SHORT       = 3'd3,
        ST_ROLLED_BACK = 3'd4,
        ST_BAD_RELEASE = 3'd5,
        ST_LOAD_REJECT = 3'd6,
        ST_UNSAFE      = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_START,
        S_SCAN,
        S_ROLLBACK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       wr_avail;
        logic       commit_req;
        logic       rollback;
        logic       do_release;
        logic       wr_max;
        logic       wr_alloc;
        logic       scan_init;
        logic       scan_step;
        logic       out_load;
        t_status    out_status;
        logic       out_last;
        logic       out_seq;
        logic [3:0] seq_idx;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    cust_ok;
        logic    over_need;
        logic    short_av;
        logic    bad_rel;
        logic    max_rej;
        logic    alloc_rej;
        logic    scan_end;
        logic    safe;
        logic    stuck;
        logic    out_last;
    } t_dp_stat;

endpackage

/* rtl/bsra_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsra_datapath
// Holds the maximum, allocation and available tables, the safety check
// scratch state, the safe sequence and the output register.
// ----------------------------------------------------------------------------
module bsra_datapath #(
    parameter int CUSTOMERS    = 8,
    parameter int AMOUNT_WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_opcode,
    input  logic [3:0]         i_customer,
    input  logic [7:0]         i_amount_0,
    input  logic [7:0]         i_amount_1,
    input  logic [7:0]         i_amount_2,
    input  bsra_pkg::t_dp_cmd  i_cmd,
    output bsra_pkg::t_dp_stat o_stat,
    output logic [2:0]         o_status,
    output logic [3:0]         o_seq_customer,
    output logic               o_last
);
    localparam int CW = $clog2(CUSTOMERS);
    localparam int DW = $clog2(CUSTOMERS + 1);
    localparam int AW = AMOUNT_WIDTH;
    localparam int WW = AW + DW;

    bsra_pkg::t_opcode r_op;
    logic [3:0]        r_cust;
    logic [AW-1:0]     r_amt   [3];
    logic [AW-1:0]     r_max   [CUSTOMERS][3];
    logic [AW-1:0]     r_alloc [CUSTOMERS][3];
    logic [AW-1:0]     r_avail [3];
    logic [WW-1:0]     r_work  [3];
    logic [CUSTOMERS-1:0] r_fin;
    logic [CW-1:0]     r_order [CUSTOMERS];
    logic [DW-1:0]     r_done;
    logic [CW-1:0]     r_c;
    logic              r_prog;
    bsra_pkg::t_status r_ostatus;
    logic [3:0]        r_oseq;
    logic              r_olast;

    logic [CW-1:0] ra;
    logic [CW-1:0] cidx;
    logic [AW-1:0] need [3];
    logic [AW:0]   rel_sum [3];
    logic fits, fits_now, prog_n;
    logic over_need, short_av, bad_rel, max_rej, alloc_rej;
    logic [DW-1:0] done_n;

    assign cidx = r_cust[CW-1:0];
    assign ra   = i_cmd.scan_step ? r_c : cidx;

    always_comb begin
        fits      = 1'b1;
        over_need = 1'b0;
        short_av  = 1'b0;
        bad_rel   = 1'b0;
        max_rej   = 1'b0;
        alloc_rej = 1'b0;
        for (int k = 0; k < 3; k++) begin
            need[k]    = r_max[ra][k] - r_alloc[ra][k];
            rel_sum[k] = {1'b0, r_avail[k]} + {1'b0, r_amt[k]};
            if (WW'(need[k]) > r_work[k]) fits = 1'b0;
            if (r_amt[k] > need[k]) over_need = 1'b1;
            if (r_amt[k] > r_avail[k]) short_av = 1'b1;
            if (r_amt[k] > r_alloc[ra][k]) bad_rel = 1'b1;
            if (r_amt[k] < r_alloc[ra][k]) max_rej = 1'b1;
            if (r_amt[k] > r_max[ra][k]) alloc_rej = 1'b1;
        end
        fits_now = fits && !r_fin[r_c];
        done_n   = r_done + DW'(fits_now);
        prog_n   = r_prog | fits_now;
    end

    always_comb begin
        o_stat.op        = r_op;
        o_stat.cust_ok   = {1'b0, r_cust} < 5'(CUSTOMERS);
        o_stat.over_need = over_need;
        o_stat.short_av  = short_av;
        o_stat.bad_rel   = bad_rel;
        o_stat.max_rej   = max_rej;
        o_stat.alloc_rej = alloc_rej;
        o_stat.scan_end  = r_c == CW'(CUSTOMERS - 1);
        o_stat.safe      = done_n == DW'(CUSTOMERS);
        o_stat.stuck     = !prog_n;
        o_stat.out_last  = r_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CUSTOMERS; c++) begin
                for (int k = 0; k < 3; k++) begin
                    r_max[c][k]   <= '0;
                    r_alloc[c][k] <= '0;
                end
            end
            for (int k = 0; k < 3; k++) begin
                r_avail[k] <= '0;
                r_work[k]  <= '0;
            end
            r_fin  <= '0;
            r_done <= '0;
            r_c    <= '0;
            r_prog <= 1'b0;
        end else begin
            if (i_cmd.wr_avail) begin
                for (int k = 0; k < 3; k++) r_avail[k] <= r_amt[k];
            end
            if (i_cmd.commit_req) begin
                for (int k = 0; k < 3; k++) begin
                    r_avail[k]       <= r_avail[k] - r_amt[k];
                    r_alloc[cidx][k] <= r_alloc[cidx][k] + r_amt[k];
                end
            end
            if (i_cmd.rollback) begin
                for (int k = 0; k < 3; k++) begin
                    r_avail[k]       <= r_avail[k] + r_amt[k];
                    r_alloc[cidx][k] <= r_alloc[cidx][k] - r_amt[k];
                end
            end
            if (i_cmd.do_release) begin
                for (int k = 0; k < 3; k++) begin
                    r_alloc[cidx][k] <= r_alloc[cidx][k] - r_amt[k];
                    r_avail[k]       <= rel_sum[k][AW] ? '1 : rel_sum[k][AW-1:0];
                end
            end
            if (i_cmd.wr_max) begin
                for (int k = 0; k < 3; k++) r_max[cidx][k] <= r_amt[k];
            end
            if (i_cmd.wr_alloc) begin
                for (int k = 0; k < 3; k++) r_alloc[cidx][k] <= r_amt[k];
            end
            if (i_cmd.scan_init) begin
                for (int k = 0; k < 3; k++) r_work[k] <= WW'(r_avail[k]);
                r_fin  <= '0;
                r_done <= '0;
                r_c    <= '0;
                r_prog <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (fits_now) begin
                    for (int k = 0; k < 3; k++) begin
                        r_work[k] <= r_work[k] + WW'(r_alloc[r_c][k]);
                    end
                    r_fin[r_c] <= 1'b1;
                end
                r_done <= done_n;
                r_c    <= o_stat.scan_end ? '0 : r_c + CW'(1);
                r_prog <= o_stat.scan_end ? 1'b0 : prog_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= bsra_pkg::t_opcode'(i_opcode);
            r_cust <= i_customer;
            r_amt[0] <= AW'(i_amount_0);
            r_amt[1] <= AW'(i_amount_1);
            r_amt[2] <= AW'(i_amount_2);
        end
        if (i_cmd.scan_step && fits_now) begin
            r_order[r_done[CW-1:0]] <= r_c;
        end
        if (i_cmd.out_load) begin
            r_ostatus <= i_cmd.out_status;
            r_olast   <= i_cmd.out_last;
            r_oseq    <= i_cmd.out_seq ? 4'(r_order[i_cmd.seq_idx[CW-1:0]]) : 4'd0;
        end
    end

    assign o_status       = r_ostatus;
    assign o_seq_customer = r_oseq;
    assign o_last         = r_olast;

endmodule

/* rtl/bsra_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsra_ctrl
// Controller state machine: decodes an operation, runs the safety scans,
// rolls back refused requests and hands out result beats.
// ----------------------------------------------------------------------------
module bsra_ctrl #(
    parameter int CUSTOMERS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    input  bsra_pkg::t_dp_stat i_stat,
    output bsra_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_valid
);
    bsra_pkg::t_state r_state, n_state;
    logic [3:0]       r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsra_pkg::S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        unique case (r_state)
            bsra_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = bsra_pkg::S_DECODE;
                end
            end
            bsra_pkg::S_DECODE: begin
                o_cmd.out_last   = 1'b1;
                o_cmd.out_status = bsra_pkg::ST_OK;
                n_state          = bsra_pkg::S_OUT;
                unique case (i_stat.op) inside
                    bsra_pkg::OP_LOAD_AVAIL: begin
                        o_cmd.wr_avail = 1'b1;
                        o_cmd.out_load = 1'b1;
                    end
                    bsra_pkg::OP_QUERY: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = bsra_pkg::S_SCAN;
                    end
                    bsra_pkg::OP_REQUEST, bsra_pkg::OP_RELEASE,
                    bsra_pkg::OP_LOAD_MAX, bsra_pkg::OP_LOAD_ALLOC: begin
                        o_cmd.out_load = 1'b1;
                        if (!i_stat.cust_ok) begin
                            o_cmd.out_status = bsra_pkg::ST_BAD_CUST;
                        end else begin
                            unique case (i_stat.op)
                                bsra_pkg::OP_REQUEST: begin
                                    if (i_stat.over_need) begin
                                        o_cmd.out_status = bsra_pkg::ST_OVER_NEED;
                                    end else if (i_stat.short_av) begin
                                        o_cmd.out_status = bsra_pkg::ST_SHORT;
                                    end else begin
                                        o_cmd.out_load   = 1'b0;
                                        o_cmd.commit_req = 1'b1;
                                        n_state          = bsra_pkg::S_START;
                                    end
                                end
                                bsra_pkg::OP_RELEASE: begin
                                    if (i_stat.bad_rel) begin
                                        o_cmd.out_status = bsra_pkg::ST_BAD_RELEASE;
                                    end else begin
                                        o_cmd.do_release = 1'b1;
                                    end
                                end
                                bsra_pkg::OP_LOAD_MAX: begin
                                    if (i_stat.max_rej) begin
                                        o_cmd.out_status = bsra_pkg::ST_LOAD_REJECT;
                                    end else begin
                                        o_cmd.wr_max = 1'b1;
                                    end
                                end
                                default: begin
                                    if (i_stat.alloc_rej) begin
                                        o_cmd.out_status = bsra_pkg::ST_LOAD_REJECT;
                                    end else begin
                                        o_cmd.wr_alloc = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    default: begin
                        n_state = bsra_pkg::S_IDLE;
                    end
                endcase
            end
            bsra_pkg::S_START: begin
                o_cmd.scan_init = 1'b1;
                n_state         = bsra_pkg::S_SCAN;
            end
            bsra_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_end) begin
                    if (i_stat.safe) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = bsra_pkg::ST_OK;
                        n_state          = bsra_pkg::S_OUT;
                        if (i_stat.op == bsra_pkg::OP_QUERY) begin
                            o_cmd.out_seq  = 1'b1;
                            o_cmd.seq_idx  = '0;
                            o_cmd.out_last = CUSTOMERS == 1;
                            n_idx          = '0;
                        end else begin
                            o_cmd.out_last = 1'b1;
                        end
                    end else if (i_stat.stuck) begin
                        if (i_stat.op == bsra_pkg::OP_QUERY) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_status = bsra_pkg::ST_UNSAFE;
                            o_cmd.out_last   = 1'b1;
                            n_state          = bsra_pkg::S_OUT;
                        end else begin
                            n_state = bsra_pkg::S_ROLLBACK;
                        end
                    end
                end
            end
            bsra_pkg::S_ROLLBACK: begin
                o_cmd.rollback   = 1'b1;
                o_cmd.out_load   = 1'b1;
                o_cmd.out_status = bsra_pkg::ST_ROLLED_BACK;
                o_cmd.out_last   = 1'b1;
                n_state          = bsra_pkg::S_OUT;
            end
            bsra_pkg::S_OUT: begin
                if (!i_stall) begin
                    if (i_stat.out_last) begin
                        n_state = bsra_pkg::S_IDLE;
                    end else begin
                        n_idx            = r_idx + 4'd1;
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = bsra_pkg::ST_OK;
                        o_cmd.out_seq    = 1'b1;
                        o_cmd.seq_idx    = n_idx;
                        o_cmd.out_last   = n_idx == 4'(CUSTOMERS - 1);
                    end
                end
            end
            default: begin
                n_state = bsra_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy  = r_state != bsra_pkg::S_IDLE;
    assign o_valid = r_state == bsra_pkg::S_OUT;

endmodule

/* rtl/bankers_safe_resource_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_safe_resource_allocator
// Deadlock-avoidance allocator for three resource types with a safety
// check made of repeated in-order scans over the customers.
//
//   channel  valid    stall    payload
//   input    i_valid  o_stall  i_opcode i_customer i_amount_0..2
//   output   o_valid  i_stall  o_status o_seq_customer o_last
//
// A load or release is captured, decoded and answered with one output beat.
// A request adds a start state for the check, then up to CUSTOMERS scans over
// all customers, one customer tested per cycle, and a rollback state for a
// refused request. A query runs the same scans without the start state and
// gives CUSTOMERS beats when safe. Synchronous reset clears all tables.
// A new beat is taken in the cycle after the last result is taken.
// ----------------------------------------------------------------------------
module bankers_safe_resource_allocator #(
    parameter int CUSTOMERS    = 8,
    parameter int AMOUNT_WIDTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_opcode,
    input  logic [3:0] i_customer,
    input  logic [7:0] i_amount_0,
    input  logic [7:0] i_amount_1,
    input  logic [7:0] i_amount_2,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [3:0] o_seq_customer,
    output logic       o_last
);
    bsra_pkg::t_dp_cmd  cmd;
    bsra_pkg::t_dp_stat stat;

    bsra_ctrl #(
        .CUSTOMERS(CUSTOMERS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_stall),
        .o_valid (o_valid)
    );

    bsra_datapath #(
        .CUSTOMERS   (CUSTOMERS),
        .AMOUNT_WIDTH(AMOUNT_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_opcode       (i_opcode),
        .i_customer     (i_customer),
        .i_amount_0     (i_amount_0),
        .i_amount_1     (i_amount_1),
        .i_amount_2     (i_amount_2),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_status       (o_status),
        .o_seq_customer (o_seq_customer),
        .o_last         (o_last)
    );

endmodule

/* test/bankers_safe_resource_allocator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_safe_resource_allocator_test
// Self-checking bench for the safe resource allocator. A behavioral
// allocator model predicts the beats of every accepted command. Directed
// tests cover each opcode and its refusal cases, then random sequences of
// table setups, requests, releases, queries and random commands follow, with
// random idle cycles on both channels.
// ----------------------------------------------------------------------------
module bankers_safe_resource_allocator_test;

    localparam int NCUST = 8;
    localparam int LIMIT = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [2:0] i_opcode = '0;
    logic [3:0] i_customer = '0;
    logic [7:0] i_amount_0 = '0;
    logic [7:0] i_amount_1 = '0;
    logic [7:0] i_amount_2 = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [2:0] o_status;
    logic [3:0] o_seq_customer;
    logic       o_last;

    bankers_safe_resource_allocator dut (.*);

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] seq;
        logic       last;
    } t_beat;

    logic [7:0] max_rows [NCUST][3];
    logic [7:0] alloc_rows [NCUST][3];
    logic [7:0] free_units [3];
    t_beat      pending_beats [$];
    int         mismatches = 0;
    int         cycles = 0;
    bit         quiet_phase = 1'b0;

    initial forever #1 i_clk = ~i_clk;

    function automatic bit find_safe_order(output logic [3:0] order [NCUST]);
        logic [11:0] work [3];
        bit          done [NCUST];
        int          count;
        bit          progress;
        bit          fits;
        for (int k = 0; k < 3; k++) work[k] = free_units[k];
        for (int c = 0; c < NCUST; c++) done[c] = 1'b0;
        count = 0;
        while (count < NCUST) begin
            progress = 1'b0;
            for (int c = 0; c < NCUST; c++) begin
                if (!done[c]) begin
                    fits = 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        if (max_rows[c][k] - alloc_rows[c][k] > work[k]) fits = 1'b0;
                    end
                    if (fits) begin
                        for (int k = 0; k < 3; k++) work[k] += alloc_rows[c][k];
                        done[c] = 1'b1;
                        order[count] = c[3:0];
                        count++;
                        progress = 1'b1;
                    end
                end
            end
            if (!progress) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void queue_beat(t_beat b);
        pending_beats = {pending_beats, b};
    endfunction

    function automatic void push_status(bsra_pkg::t_status st);
        queue_beat('{status: st, seq: 4'd0, last: 1'b1});
    endfunction

    function automatic void predict_command(logic [2:0] op, logic [3:0] cust,
                                            logic [7:0] amt [3]);
        logic [3:0] order [NCUST];
        bit         bad;
        logic [8:0] sum;
        if (op == bsra_pkg::OP_LOAD_AVAIL) begin
            for (int k = 0; k < 3; k++) free_units[k] = amt[k];
            push_status(bsra_pkg::ST_OK);
            return;
        end
        if (op == bsra_pkg::OP_QUERY) begin
            if (!find_safe_order(order)) begin
                push_status(bsra_pkg::ST_UNSAFE);
            end else begin
                for (int i = 0; i < NCUST; i++)
                    queue_beat('{status: bsra_pkg::ST_OK, seq: order[i],
                                 last: (i == NCUST - 1)});
            end
            return;
        end
        if (op > bsra_pkg::OP_QUERY) return;
        if (cust >= NCUST) begin
            push_status(bsra_pkg::ST_BAD_CUST);
            return;
        end
        bad = 1'b0;
        case (op)
            bsra_pkg::OP_REQUEST: begin
                for (int k = 0; k < 3; k++)
                    if (amt[k] > max_rows[cust][k] - alloc_rows[cust][k]) bad = 1'b1;
                if (bad) begin
                    push_status(bsra_pkg::ST_OVER_NEED);
                    return;
                end
                for (int k = 0; k < 3; k++) if (amt[k] > free_units[k]) bad = 1'b1;
                if (bad) begin
                    push_status(bsra_pkg::ST_SHORT);
                    return;
                end
                for (int k = 0; k < 3; k++) begin
                    free_units[k] -= amt[k];
                    alloc_rows[cust][k] += amt[k];
                end
                if (find_safe_order(order)) begin
                    push_status(bsra_pkg::ST_OK);
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        free_units[k] += amt[k];
                        alloc_rows[cust][k] -= amt[k];
                    end
                    push_status(bsra_pkg::ST_ROLLED_BACK);
                end
            end
            bsra_pkg::OP_RELEASE: begin
                for (int k = 0; k < 3; k++) if (amt[k] > alloc_rows[cust][k]) bad = 1'b1;
                if (bad) begin
                    push_status(bsra_pkg::ST_BAD_RELEASE);
                    return;
                end
                for (int k = 0; k < 3; k++) begin
                    sum = free_units[k] + amt[k];
                    alloc_rows[cust][k] -= amt[k];
                    free_units[k] = sum[8] ? 8'hff : sum[7:0];
                end
                push_status(bsra_pkg::ST_OK);
            end
            bsra_pkg::OP_LOAD_MAX: begin
                for (int k = 0; k < 3; k++) if (amt[k] < alloc_rows[cust][k]) bad = 1'b1;
                if (bad) begin
                    push_status(bsra_pkg::ST_LOAD_REJECT);
                    return;
                end
                for (int k = 0; k < 3; k++) max_rows[cust][k] = amt[k];
                push_status(bsra_pkg::ST_OK);
            end
            default: begin
                for (int k = 0; k < 3; k++) if (amt[k] > max_rows[cust][k]) bad = 1'b1;
                if (bad) begin
                    push_status(bsra_pkg::ST_LOAD_REJECT);
                    return;
                end
                for (int k = 0; k < 3; k++) alloc_rows[cust][k] = amt[k];
                push_status(bsra_pkg::ST_OK);
            end
        endcase
    endfunction

    function automatic bit idle_now();
        return !quiet_phase && ($urandom_range(99) < 8);
    endfunction

    task automatic send_command(logic [2:0] op, logic [3:0] cust,
                                logic [7:0] a0, logic [7:0] a1, logic [7:0] a2);
        logic [7:0] amt [3];
        amt[0] = a0;
        amt[1] = a1;
        amt[2] = a2;
        while (idle_now()) @(posedge i_clk);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_customer <= cust;
        i_amount_0 <= a0;
        i_amount_1 <= a1;
        i_amount_2 <= a2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_command(op, cust, amt);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_beat want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            i_stall <= idle_now();
            if (o_valid && !i_stall) begin
                if (pending_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: status %0d seq %0d last %0d",
                                 o_status, o_seq_customer, o_last);
                end else begin
                    want = pending_beats.pop_front();
                    if (want != {o_status, o_seq_customer, o_last}) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.status, want.seq, want.last,
                                     o_status, o_seq_customer, o_last);
                    end
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("bankers_safe_resource_allocator_test: done, errors");
            $finish;
        end
    end

    task automatic test_loads_and_bad_customers();
        send_command(bsra_pkg::OP_QUERY, 4'd0, 8'd0, 8'd0, 8'd0);
        send_command(bsra_pkg::OP_LOAD_AVAIL, 4'd15, 8'hff, 8'hff, 8'hff);
        send_command(bsra_pkg::OP_LOAD_MAX, 4'd0, 8'hff, 8'hff, 8'hff);
        send_command(bsra_pkg::OP_LOAD_ALLOC, 4'd0, 8'd5, 8'd0, 8'hff);
        send_command(bsra_pkg::OP_LOAD_MAX, 4'd0, 8'd4, 8'hff, 8'hff);
        send_command(bsra_pkg::OP_LOAD_ALLOC, 4'd1, 8'd1, 8'd0, 8'd0);
        for (int op = bsra_pkg::OP_REQUEST; op <= bsra_pkg::OP_LOAD_ALLOC; op++)
            send_command(op[2:0], 4'd8 + op[3:0], 8'd0, 8'd0, 8'd0);
        send_command(bsra_pkg::OP_REQUEST, 4'd15, 8'd0, 8'd0, 8'd0);
        send_command(3'd6, 4'd0, 8'd1, 8'd1, 8'd1);
        send_command(3'd7, 4'd0, 8'd1, 8'd1, 8'd1);
    endtask

    task automatic test_request_release();
        send_command(bsra_pkg::OP_LOAD_MAX, 4'd1, 8'd10, 8'd10, 8'd10);
        send_command(bsra_pkg::OP_REQUEST, 4'd1, 8'd11, 8'd0, 8'd0);
        send_command(bsra_pkg::OP_LOAD_AVAIL, 4'd0, 8'd3, 8'd3, 8'd3);
        send_command(bsra_pkg::OP_REQUEST, 4'd1, 8'd4, 8'd0, 8'd0);
        send_command(bsra_pkg::OP_REQUEST, 4'd1, 8'd3, 8'd3, 8'd3);
        send_command(bsra_pkg::OP_QUERY, 4'd0, 8'd0, 8'd0, 8'd0);
        send_command(bsra_pkg::OP_RELEASE, 4'd1, 8'd4, 8'd0, 8'd0);
        send_command(bsra_pkg::OP_RELEASE, 4'd1, 8'd3, 8'd3, 8'd3);
        send_command(bsra_pkg::OP_LOAD_AVAIL, 4'd0, 8'd250, 8'd0, 8'd0);
        send_command(bsra_pkg::OP_LOAD_ALLOC, 4'd1, 8'd10, 8'd0, 8'd0);
        send_command(bsra_pkg::OP_RELEASE, 4'd1, 8'd10, 8'd0, 8'd0);
        send_command(bsra_pkg::OP_LOAD_MAX, 4'd2, 8'd200, 8'd200, 8'd200);
        send_command(bsra_pkg::OP_LOAD_AVAIL, 4'd0, 8'd100, 8'd100, 8'd100);
        send_command(bsra_pkg::OP_REQUEST, 4'd2, 8'd50, 8'd50, 8'd50);
        send_command(bsra_pkg::OP_QUERY, 4'd0, 8'd0, 8'd0, 8'd0);
        quiet_phase = 1'b1;
        wait_drained();
        quiet_phase = 1'b0;
    endtask

    task automatic test_random_sequences();
        logic [7:0] a [3];
        int         c;
        int         pick;
        for (int n = 0; n < 250; n++) begin
            quiet_phase = (n >= 100) && (n < 150);
            c = $urandom_range(NCUST - 1);
            pick = $urandom_range(99);
            for (int k = 0; k < 3; k++) begin
                a[k] = (pick < 75) ? 8'($urandom_range(max_rows[c][k] > 0 ?
                                                     max_rows[c][k] : 8)) : 8'($urandom);
            end
            if (pick < 8) begin
                send_command(bsra_pkg::OP_LOAD_MAX, c[3:0],
                             8'($urandom_range(40)) + alloc_rows[c][0],
                             8'($urandom_range(40)) + alloc_rows[c][1],
                             8'($urandom_range(40)) + alloc_rows[c][2]);
            end else if (pick < 12) begin
                send_command(bsra_pkg::OP_LOAD_AVAIL, 4'($urandom),
                             8'($urandom_range(60)), 8'($urandom_range(60)),
                             8'($urandom_range(60)));
            end else if (pick < 40) begin
                send_command(bsra_pkg::OP_REQUEST, c[3:0],
                             8'($urandom_range(max_rows[c][0] - alloc_rows[c][0])),
                             8'($urandom_range(max_rows[c][1] - alloc_rows[c][1])),
                             8'($urandom_range(max_rows[c][2] - alloc_rows[c][2])));
            end else if (pick < 55) begin
                send_command(bsra_pkg::OP_RELEASE, c[3:0],
                             8'($urandom_range(alloc_rows[c][0])),
                             8'($urandom_range(alloc_rows[c][1])),
                             8'($urandom_range(alloc_rows[c][2])));
            end else if (pick < 62) begin
                send_command(bsra_pkg::OP_LOAD_ALLOC, c[3:0], a[0], a[1], a[2]);
            end else if (pick < 75) begin
                send_command(bsra_pkg::OP_QUERY, 4'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom));
            end else begin
                send_command(3'($urandom), 4'($urandom), a[0], a[1], a[2]);
            end
        end
        quiet_phase = 1'b0;
    endtask

    initial begin
        for (int c = 0; c < NCUST; c++)
            for (int k = 0; k < 3; k++) begin
                max_rows[c][k] = '0;
                alloc_rows[c][k] = '0;
            end
        for (int k = 0; k < 3; k++) free_units[k] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_loads_and_bad_customers();
        test_request_release();
        test_random_sequences();
        wait_drained();
        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("bankers_safe_resource_allocator_test: done, clean");
        end else begin
            $display("bankers_safe_resource_allocator_test: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bsra_pkg.sv
rtl/bsra_datapath.sv
rtl/bsra_ctrl.sv
rtl/bankers_safe_resource_allocator.sv
test/bankers_safe_resource_allocator_test.sv
